/* hdl/c2d_pkg.sv */
// shared constants, types and codes of the multi-map convolution block
`timescale 1ns / 1ps
package c2d_pkg;

  localparam int KernelSize  = 10;
  localparam int FeatureMaps = 2;
  localparam int MaxWidth    = 512;

  localparam int KArea     = KernelSize * KernelSize;
  localparam int NWeights  = FeatureMaps * KArea;
  localparam int RowSlots  = (KernelSize > 1) ? KernelSize - 1 : 1;

  localparam int KW       = (KernelSize > 1) ? $clog2(KernelSize) : 1;
  localparam int SW       = $clog2(KernelSize + 1);
  localparam int SlotW    = (RowSlots > 1) ? $clog2(RowSlots) : 1;
  localparam int MapW     = (FeatureMaps > 1) ? $clog2(FeatureMaps) : 1;
  localparam int KAddrW   = (NWeights > 1) ? $clog2(NWeights) : 1;
  localparam int WinAddrW = (KArea > 1) ? $clog2(KArea) : 1;
  localparam int RowAddrW = $clog2(RowSlots * MaxWidth);
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = 12;
  localparam int ProdW    = 33;
  localparam int SumW     = 48;
  localparam int CfgIdxW  = 2;

  // item commands
  localparam logic CmdWeight = 1'b0;
  localparam logic CmdPixel  = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic wt_write;
    logic px_load;
    logic fetch_step;
    logic mac_start;
    logic next_map;
    logic mac_issue;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fetch_done;
    logic need_out;
    logic mac_last;
    logic pipe_busy;
    logic last_map;
  } dp_status_t;

endpackage

/* hdl/c2d_ctrl.sv */
// controller state machine sequencing fetch, multiply-accumulate and output
`timescale 1ns / 1ps
module c2d_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  c2d_pkg::dp_status_t status_i,
  output c2d_pkg::ctrl_cmd_t  cmd_o
);

  c2d_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c2d_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      c2d_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cmd_i == c2d_pkg::CmdPixel) begin
            cmd_o.px_load = 1'b1;
            state_d       = c2d_pkg::ST_FETCH;
          end else begin
            cmd_o.wt_write = 1'b1;
          end
        end
      end
      c2d_pkg::ST_FETCH: begin
        cmd_o.fetch_step = 1'b1;
        if (status_i.fetch_done) begin
          if (status_i.need_out) begin
            cmd_o.mac_start = 1'b1;
            state_d         = c2d_pkg::ST_MAC;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = c2d_pkg::ST_IDLE;
          end
        end
      end
      c2d_pkg::ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (status_i.mac_last) begin
          state_d = c2d_pkg::ST_DRAIN;
        end
      end
      c2d_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = c2d_pkg::ST_OUT;
        end
      end
      c2d_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last_map) begin
            cmd_o.advance = 1'b1;
            state_d       = c2d_pkg::ST_IDLE;
          end else begin
            cmd_o.next_map = 1'b1;
            state_d        = c2d_pkg::ST_MAC;
          end
        end
      end
      default: begin
        state_d = c2d_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/c2d_dp.sv */
// datapath: line buffer, window store, kernel store, counters and mac unit
`timescale 1ns / 1ps
module c2d_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  c2d_pkg::ctrl_cmd_t            cmd_i,
  output c2d_pkg::dp_status_t           status_o,
  input  logic                          cfg_valid_i,
  input  logic [c2d_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [11:0]                   cfg_data_i,
  input  logic [7:0]                    weight_index_i,
  input  logic signed [15:0]            weight_value_i,
  input  logic [15:0]                   pixel_i,
  output logic [0:0]                    feature_map_o,
  output logic [11:0]                   out_row_o,
  output logic [8:0]                    out_col_o,
  output logic signed [47:0]            conv_sum_o,
  output logic                          last_o
);

  localparam int K = c2d_pkg::KernelSize;

  logic [9:0]                      width_q;
  logic [11:0]                     height_q;
  logic [c2d_pkg::RowW-1:0]        row_q;
  logic [c2d_pkg::ColW-1:0]        col_q;
  logic [c2d_pkg::SlotW-1:0]       rs_q;
  logic [c2d_pkg::KW-1:0]          cm_q;
  logic [15:0]                     px_q;
  logic [c2d_pkg::SW-1:0]          s_q;
  logic [15:0]                     rd_q;
  logic [c2d_pkg::KW-1:0]          kr_q, jc_q, sl_q;
  logic [c2d_pkg::KAddrW-1:0]      ka_q;
  logic [c2d_pkg::MapW-1:0]        map_q;
  logic                            v1_q, v2_q;
  logic signed [15:0]              kd_q;
  logic [15:0]                     wd_q;
  logic signed [c2d_pkg::ProdW-1:0] prod_q;
  logic signed [c2d_pkg::SumW-1:0] acc_q;

  logic [15:0]        row_mem [c2d_pkg::RowSlots*c2d_pkg::MaxWidth];
  logic signed [15:0] ker_mem [c2d_pkg::NWeights];
  logic [15:0]        win_mem [c2d_pkg::KArea];

  logic [12:0]               eff_w, eff_h;
  logic [c2d_pkg::SlotW:0]   slot_sum;
  logic [c2d_pkg::SlotW-1:0] rd_slot;
  logic [c2d_pkg::KW-1:0]    sl_start;
  logic [c2d_pkg::SW-1:0]    w_row;
  logic                      need_out;

  // effective image size
  always_comb begin
    eff_w = {3'd0, width_q};
    if (eff_w > 13'(c2d_pkg::MaxWidth)) eff_w = 13'(c2d_pkg::MaxWidth);
    if (eff_w < 13'(K)) eff_w = 13'(K);
    eff_h = {1'b0, height_q};
    if (eff_h < 13'(K)) eff_h = 13'(K);
  end

  // line buffer slot of the row read at this fetch step
  always_comb begin
    slot_sum = {1'b0, rs_q} + (c2d_pkg::SlotW+1)'(s_q);
    if (slot_sum >= (c2d_pkg::SlotW+1)'(c2d_pkg::RowSlots)) begin
      slot_sum = slot_sum - (c2d_pkg::SlotW+1)'(c2d_pkg::RowSlots);
    end
    rd_slot  = slot_sum[c2d_pkg::SlotW-1:0];
    sl_start = (cm_q == c2d_pkg::KW'(K - 1)) ? '0 : cm_q + 1'b1;
    w_row    = s_q - 1'b1;
    need_out = (row_q >= c2d_pkg::RowW'(K - 1)) && (col_q >= c2d_pkg::ColW'(K - 1));
  end

  // kernel store write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wt_write && (int'(weight_index_i) < c2d_pkg::NWeights)) begin
      ker_mem[weight_index_i[c2d_pkg::KAddrW-1:0]] <= weight_value_i;
    end
  end

  // line buffer read and write ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_step && (int'(s_q) < K - 1)) begin
      rd_q <= row_mem[c2d_pkg::RowAddrW'(int'(rd_slot) * c2d_pkg::MaxWidth + int'(col_q))];
    end
    if (K > 1 && cmd_i.fetch_step && (int'(s_q) == K)) begin
      row_mem[c2d_pkg::RowAddrW'(int'(rs_q) * c2d_pkg::MaxWidth + int'(col_q))] <= px_q;
    end
  end

  // window store: one column entry per fetch step
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_step && s_q != '0) begin
      win_mem[c2d_pkg::WinAddrW'(int'(w_row) * K + int'(cm_q))] <=
        (int'(w_row) == K - 1) ? px_q : rd_q;
    end
  end

  // mac operand reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_issue) begin
      kd_q <= ker_mem[ka_q];
      wd_q <= win_mem[c2d_pkg::WinAddrW'(int'(kr_q) * K + int'(sl_q))];
    end
    prod_q <= $signed({1'b0, wd_q}) * kd_q;
  end

  // pixel latch and fetch step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q  <= '0;
      px_q <= '0;
    end else if (cmd_i.px_load) begin
      s_q  <= '0;
      px_q <= pixel_i;
    end else if (cmd_i.fetch_step && !status_o.fetch_done) begin
      s_q <= s_q + 1'b1;
    end
  end

  // mac sequencing and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kr_q  <= '0;
      jc_q  <= '0;
      sl_q  <= '0;
      ka_q  <= '0;
      map_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
      if (v2_q) begin
        acc_q <= acc_q + c2d_pkg::SumW'(prod_q);
      end
      if (cmd_i.mac_start || cmd_i.next_map) begin
        kr_q  <= '0;
        jc_q  <= '0;
        sl_q  <= sl_start;
        acc_q <= '0;
        if (cmd_i.mac_start) begin
          ka_q  <= '0;
          map_q <= '0;
        end else begin
          map_q <= map_q + 1'b1;
        end
      end else if (cmd_i.mac_issue) begin
        ka_q <= ka_q + 1'b1;
        if (jc_q == c2d_pkg::KW'(K - 1)) begin
          jc_q <= '0;
          kr_q <= kr_q + 1'b1;
          sl_q <= sl_start;
        end else begin
          jc_q <= jc_q + 1'b1;
          sl_q <= (sl_q == c2d_pkg::KW'(K - 1)) ? '0 : sl_q + 1'b1;
        end
      end
    end
  end

  // configuration registers and raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 10'd400;
      height_q <= 12'd400;
      row_q    <= '0;
      col_q    <= '0;
      rs_q     <= '0;
      cm_q     <= '0;
    end else if (cfg_valid_i &&
                 (cfg_index_i == c2d_pkg::RegWidth || cfg_index_i == c2d_pkg::RegHeight)) begin
      if (cfg_index_i == c2d_pkg::RegWidth) begin
        width_q <= cfg_data_i[9:0];
      end else begin
        height_q <= cfg_data_i;
      end
      row_q <= '0;
      col_q <= '0;
      rs_q  <= '0;
      cm_q  <= '0;
    end else if (cmd_i.advance) begin
      if ((13'(col_q) + 13'd1) >= eff_w) begin
        col_q <= '0;
        cm_q  <= '0;
        if ((13'(row_q) + 13'd1) >= eff_h) begin
          row_q <= '0;
          rs_q  <= '0;
        end else begin
          row_q <= row_q + 1'b1;
          rs_q  <= (int'(rs_q) == c2d_pkg::RowSlots - 1) ? '0 : rs_q + 1'b1;
        end
      end else begin
        col_q <= col_q + 1'b1;
        cm_q  <= (cm_q == c2d_pkg::KW'(K - 1)) ? '0 : cm_q + 1'b1;
      end
    end
  end

  // status and result fields
  always_comb begin
    status_o.fetch_done = (int'(s_q) == K);
    status_o.need_out   = need_out;
    status_o.mac_last   = (kr_q == c2d_pkg::KW'(K - 1)) && (jc_q == c2d_pkg::KW'(K - 1));
    status_o.pipe_busy  = v1_q || v2_q;
    status_o.last_map   = (int'(map_q) == c2d_pkg::FeatureMaps - 1);
    feature_map_o       = map_q[0];
    out_row_o           = 12'(row_q - c2d_pkg::RowW'(K - 1));
    out_col_o           = 9'(col_q - c2d_pkg::ColW'(K - 1));
    conv_sum_o          = acc_q;
    last_o              = status_o.last_map;
  end

`ifndef NO_ASSERTIONS
  a_mac_needs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mac_issue |-> need_out) else $error("mac issued without full window");
  a_retire_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> !v1_q && !v2_q) else $error("pixel retired with mac in flight");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fetch_step |-> int'(s_q) <= K) else $error("fetch step overrun");
`endif

endmodule

/* hdl/conv2d_valid_multi_map.sv */
// top level of the multi-map valid 2d convolution block
// weight beat: kernel store write while idle. pixel beat: line buffer fetch steps, one read a cycle
// when the window is full, each map then runs its multiply-accumulates on the single mac unit,
// then waits for its result beat to be taken; next beat accepted after the last result leaves
// async active-low reset clears control, counters and registers (width and height to 400)
// line buffer and kernel store are not cleared; no clearing pass
`timescale 1ns / 1ps
module conv2d_valid_multi_map (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [c2d_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [11:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [7:0]                  weight_index_i,
  input  logic signed [15:0]          weight_value_i,
  input  logic [15:0]                 pixel_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [0:0]                  feature_map_o,
  output logic [11:0]                 out_row_o,
  output logic [8:0]                  out_col_o,
  output logic signed [47:0]          conv_sum_o,
  output logic                        last_o
);

  c2d_pkg::ctrl_cmd_t  cmd;
  c2d_pkg::dp_status_t status;

  // configuration writes land at once
  assign cfg_ready_o = 1'b1;

  c2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  c2d_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .weight_index_i (weight_index_i),
    .weight_value_i (weight_value_i),
    .pixel_i        (pixel_i),
    .feature_map_o  (feature_map_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .conv_sum_o     (conv_sum_o),
    .last_o         (last_o)
  );

endmodule

/* tb/tb_top.sv */
// self-checking testbench of the multi-map valid 2d convolution block
`timescale 1ns / 1ps
module tb_top;

  localparam logic [c2d_pkg::CfgIdxW-1:0] RegSpare = 2'd2;  // not a register, write is ignored
  localparam int IdleWait = 40;

  typedef struct {
    logic        fm;
    logic [11:0] row;
    logic [8:0]  col;
    logic [47:0] sum;
    logic        last;
  } conv_res_t;

  typedef struct {
    logic        cmd;
    logic [7:0]  idx;
    logic [15:0] val;
    logic [15:0] pix;
    int          reps;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [c2d_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = c2d_pkg::CmdWeight;
  logic [7:0] weight_index_i = '0;
  logic signed [15:0] weight_value_i = '0;
  logic [15:0] pixel_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [0:0] feature_map_o;
  logic [11:0] out_row_o;
  logic [8:0] out_col_o;
  logic signed [47:0] conv_sum_o;
  logic last_o;

  // predictor state
  logic [15:0] line_mem [c2d_pkg::RowSlots*c2d_pkg::MaxWidth];
  logic signed [15:0] kern_mem [c2d_pkg::NWeights];
  logic [15:0] win_reg [c2d_pkg::KArea];
  int unsigned row_pos, col_pos, cfg_w, cfg_h;

  conv_res_t sums_due[$];
  int errors = 0;
  int results_seen = 0;
  bit no_idle = 1'b0;
  bit stim_done = 1'b0;

  conv2d_valid_multi_map dut (.*);

  always #6 clk_i = ~clk_i;

  // fixed time limit
  initial begin
    #60ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // window shift, line buffer update and per-map sums for one pixel
  function automatic void predict_pixel(logic [15:0] px);
    int unsigned col, k, j, m, i, ew, eh;
    logic [15:0] v;
    longint acc;
    conv_res_t r;
    col = col_pos % c2d_pkg::MaxWidth;
    for (k = 0; k < c2d_pkg::KernelSize; k++) begin
      for (j = 0; j + 1 < c2d_pkg::KernelSize; j++)
        win_reg[k*c2d_pkg::KernelSize+j] = win_reg[k*c2d_pkg::KernelSize+j+1];
      v = '0;
      if (k == c2d_pkg::KernelSize - 1) v = px;
      else if (row_pos + k >= c2d_pkg::KernelSize - 1)
        v = line_mem[((row_pos + k - (c2d_pkg::KernelSize - 1)) % c2d_pkg::RowSlots)
                     * c2d_pkg::MaxWidth + col];
      win_reg[k*c2d_pkg::KernelSize+c2d_pkg::KernelSize-1] = v;
    end
    line_mem[(row_pos % c2d_pkg::RowSlots) * c2d_pkg::MaxWidth + col] = px;
    if (row_pos >= c2d_pkg::KernelSize - 1 && col_pos >= c2d_pkg::KernelSize - 1) begin
      for (m = 0; m < c2d_pkg::FeatureMaps; m++) begin
        acc = 0;
        for (i = 0; i < c2d_pkg::KArea; i++)
          acc += longint'(win_reg[i]) * longint'(kern_mem[m*c2d_pkg::KArea+i]);
        r.fm   = m[0];
        r.row  = 12'(row_pos - (c2d_pkg::KernelSize - 1));
        r.col  = 9'(col_pos - (c2d_pkg::KernelSize - 1));
        r.sum  = acc[47:0];
        r.last = (m == c2d_pkg::FeatureMaps - 1);
        sums_due.push_back(r);
      end
    end
    // effective sizes after clamping
    ew = (cfg_w > c2d_pkg::MaxWidth) ? c2d_pkg::MaxWidth : cfg_w;
    if (ew < c2d_pkg::KernelSize) ew = c2d_pkg::KernelSize;
    eh = (cfg_h < c2d_pkg::KernelSize) ? c2d_pkg::KernelSize : cfg_h;
    if (col_pos + 1 >= ew) begin
      col_pos = 0;
      if (row_pos + 1 >= eh) row_pos = 0;
      else row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  // one input beat, predicted when accepted
  task automatic send_item(logic cmd, logic [7:0] idx, logic [15:0] val, logic [15:0] pix);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    cmd_i <= cmd;
    weight_index_i <= idx;
    weight_value_i <= val;
    pixel_i <= pix;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == c2d_pkg::CmdPixel) predict_pixel(pix);
    else if (idx < c2d_pkg::NWeights) kern_mem[idx] = val;
  endtask

  // register write once the block has drained
  task automatic write_reg(logic [c2d_pkg::CfgIdxW-1:0] idx, logic [11:0] data);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (sums_due.size() == 0);
    repeat (IdleWait) @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == c2d_pkg::RegWidth) cfg_w = data[9:0];
    else if (idx == c2d_pkg::RegHeight) cfg_h = data;
    if (idx == c2d_pkg::RegWidth || idx == c2d_pkg::RegHeight) begin
      row_pos = 0;
      col_pos = 0;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_size(int w, int h);
    write_reg(c2d_pkg::RegWidth, 12'(w));
    write_reg(c2d_pkg::RegHeight, 12'(h));
  endtask

  // stimulus
  initial begin
    stim_row_t dir_tab[$];
    int n, r, plen, p;
    cfg_w = 400;
    cfg_h = 400;
    row_pos = 0;
    col_pos = 0;
    foreach (win_reg[i]) win_reg[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // load every weight before any pixel
    for (int i = 0; i < c2d_pkg::NWeights; i++)
      send_item(c2d_pkg::CmdWeight, 8'(i), 16'($urandom), 16'h0);

    // directed: extreme weights, ignored indexes, extreme pixels, rewrite mid-image
    dir_tab = '{
      '{c2d_pkg::CmdWeight, 8'd0,   16'h7fff, 16'h0,    1},
      '{c2d_pkg::CmdWeight, 8'd199, 16'h8000, 16'h0,    1},
      '{c2d_pkg::CmdWeight, 8'd200, 16'h0001, 16'h0,    1},
      '{c2d_pkg::CmdWeight, 8'd255, 16'hffff, 16'h0,    1},
      '{c2d_pkg::CmdPixel,  8'd0,   16'h0,    16'hffff, 99},
      '{c2d_pkg::CmdPixel,  8'd0,   16'h0,    16'h0,    1},
      '{c2d_pkg::CmdPixel,  8'd0,   16'h0,    16'h0,    100},
      '{c2d_pkg::CmdPixel,  8'd0,   16'h0,    16'hffff, 60},
      '{c2d_pkg::CmdWeight, 8'd5,   16'h8000, 16'h0,    1},
      '{c2d_pkg::CmdWeight, 8'd105, 16'h7fff, 16'h0,    1},
      '{c2d_pkg::CmdPixel,  8'd0,   16'h0,    16'hffff, 40}
    };
    set_size(10, 10);
    foreach (dir_tab[i])
      for (int j = 0; j < dir_tab[i].reps; j++)
        send_item(dir_tab[i].cmd, dir_tab[i].idx, dir_tab[i].val, dir_tab[i].pix);

    // largest sizes, clamp of an over-wide row, then clamp from zero
    set_size(1023, 4095);
    for (int j = 0; j < 40; j++) send_item(c2d_pkg::CmdPixel, 8'd0, 16'h0, 16'($urandom));
    write_reg(RegSpare, 12'hfff);
    for (int j = 0; j < 20; j++) send_item(c2d_pkg::CmdPixel, 8'd0, 16'h0, 16'($urandom));
    set_size(0, 0);
    for (int j = 0; j < 110; j++) send_item(c2d_pkg::CmdPixel, 8'd0, 16'h0, 16'($urandom));

    // random phases on small images
    n = 0;
    while (n < 850) begin
      set_size($urandom_range(10, 13), $urandom_range(10, 13));
      no_idle = ($urandom_range(0, 3) == 0);
      plen = $urandom_range(100, 250);
      for (int j = 0; j < plen; j++) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          p = $urandom_range(0, 9);
          send_item(c2d_pkg::CmdPixel, 8'd0, 16'h0,
                    p == 0 ? 16'h0 : (p == 1 ? 16'hffff : 16'($urandom)));
        end else begin
          send_item(c2d_pkg::CmdWeight, 8'($urandom_range(0, 255)), 16'($urandom), 16'h0);
        end
        n++;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver readiness with one long hold-off
  initial begin
    int hold;
    bit pressed;
    hold = 0;
    pressed = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!pressed && results_seen >= 30) begin
        pressed = 1'b1;
        hold = 3000;
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        if ($urandom_range(0, 9) == 0) hold = $urandom_range(10, 40);
      end
    end
  end

  // compare result beats against the oldest predicted sum
  always @(posedge clk_i) begin
    conv_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected result beat map %0d row %0d col %0d sum %0d",
                 $time, feature_map_o, out_row_o, out_col_o, conv_sum_o);
        errors++;
      end else begin
        e = sums_due.pop_front();
        if (feature_map_o !== e.fm || out_row_o !== e.row || out_col_o !== e.col ||
            conv_sum_o !== e.sum || last_o !== e.last) begin
          $display("%0t: mismatch expected map %0d row %0d col %0d sum %0d last %0d",
                   $time, e.fm, e.row, e.col, $signed(e.sum), e.last);
          $display("%0t:            actual map %0d row %0d col %0d sum %0d last %0d",
                   $time, feature_map_o, out_row_o, out_col_o, conv_sum_o, last_o);
          errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (sums_due.size() == 0);
    repeat (IdleWait) @(posedge clk_i);
    if (errors == 0 && sums_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* conv2d_valid_multi_map.f */
hdl/c2d_pkg.sv
hdl/c2d_ctrl.sv
hdl/c2d_dp.sv
hdl/conv2d_valid_multi_map.sv
tb/tb_top.sv
